@@ src/buddy_block_allocator_macros.svh @@
// Assertion macros shared by the buddy allocator RTL.
// No dependencies; every macro samples on clk and is disabled while rst_n is low.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Checks that prop holds at every rising edge outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cond at one edge implies prop at the same edge.
`define BBA_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

@@ src/bba_pkg.sv @@
// Package for the buddy block allocator: sizes, link markers, codes and types.
// Used by bba_mem, bba_heads and buddy_block_allocator; depends on nothing.
package bba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int MAX_LEVELS = 11;
  localparam int IDX_W      = 10;
  localparam int LINK_W     = 11;
  localparam int LVL_W      = 4;
  localparam int CNT_W      = 11;

  localparam logic [LINK_W-1:0] LINK_NULL  = 11'd1024;
  localparam logic [LINK_W-1:0] LINK_OUT   = 11'd1025;
  localparam logic [LVL_W-1:0]  LEVEL_NONE = 4'hF;
  localparam logic [LVL_W-1:0]  ROOT_MAX   = 4'(MAX_LEVELS - 1);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // One entry of the block store.
  typedef struct packed {
    logic              mark;
    logic [LVL_W-1:0]  lvl;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] next;
  } entry_t;

  // Write request with a per-field write enable.
  typedef struct packed {
    logic             we_prev;
    logic             we_next;
    logic             we_lvl;
    logic             we_mark;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_t;

  // Smallest non-empty level that fits a request.
  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] lvl;
    logic [IDX_W-1:0] head;
  } fit_t;

  // Level whose block size is the request rounded up to a power of two.
  function automatic logic [LVL_W-1:0] ceil_lvl(input logic [CNT_W-1:0] size);
    logic [CNT_W-1:0] s;
    logic [LVL_W-1:0] l;
    s = (size == '0) ? CNT_W'(1) : size;
    l = LVL_W'(MAX_LEVELS);
    for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
      if ((12'(1) << k) >= {1'b0, s}) l = LVL_W'(k);
    end
    return l;
  endfunction

endpackage

@@ src/bba_mem.sv @@
// Block store of the buddy allocator: links, level and allocated mark per block.
// Synchronous memory, one read and one field-masked write per cycle; uses bba_pkg.
module bba_mem import bba_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data,
  input  wr_t              wr
);

  logic [LINK_W-1:0] prev_m [NUM_BLOCKS];
  logic [LINK_W-1:0] next_m [NUM_BLOCKS];
  logic [LVL_W-1:0]  lvl_m  [NUM_BLOCKS];
  logic              mark_m [NUM_BLOCKS];

  // Registered read of all fields of one entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.mark <= mark_m[rd_addr];
      rd_data.lvl  <= lvl_m[rd_addr];
      rd_data.prev <= prev_m[rd_addr];
      rd_data.next <= next_m[rd_addr];
    end
  end

  // Field-masked write.
  always_ff @(posedge clk) begin
    if (wr.we_prev) prev_m[wr.addr] <= wr.data.prev;
    if (wr.we_next) next_m[wr.addr] <= wr.data.next;
    if (wr.we_lvl)  lvl_m[wr.addr]  <= wr.data.lvl;
    if (wr.we_mark) mark_m[wr.addr] <= wr.data.mark;
  end

endmodule

@@ src/bba_heads.sv @@
// Free list heads of the buddy allocator, with fit search and largest-free scan.
// Register file of one head per level; uses bba_pkg.
module bba_heads import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              wr_en,
  input  logic [LVL_W-1:0]  wr_lvl,
  input  logic [LINK_W-1:0] wr_val,
  input  logic [LVL_W-1:0]  eff,
  input  logic [LVL_W-1:0]  req_lvl,
  input  logic [LVL_W-1:0]  sel_lvl,
  output logic [LINK_W-1:0] head_sel,
  output fit_t              fit,
  output logic [CNT_W-1:0]  largest
);

  logic [LINK_W-1:0] head_r [MAX_LEVELS];

  // Head update; a clear empties every list.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int k = 0; k < MAX_LEVELS; k++) head_r[k] <= LINK_NULL;
    end else if (wr_en && (wr_lvl <= ROOT_MAX)) begin
      head_r[wr_lvl] <= wr_val;
    end
  end

  assign head_sel = (sel_lvl <= ROOT_MAX) ? head_r[sel_lvl] : LINK_NULL;

  // Lowest non-empty level between the request and the root.
  always_comb begin
    fit = '0;
    for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
      if ((LVL_W'(k) >= req_lvl) && (LVL_W'(k) <= eff) && !head_r[k][LINK_W-1]) begin
        fit.found = 1'b1;
        fit.lvl   = LVL_W'(k);
        fit.head  = head_r[k][IDX_W-1:0];
      end
    end
  end

  // Highest non-empty level gives the largest free block.
  always_comb begin
    largest = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if ((LVL_W'(k) <= eff) && !head_r[k][LINK_W-1]) largest = CNT_W'(1) << k;
    end
  end

endmodule

@@ src/buddy_block_allocator.sv @@
// Buddy block allocator top level: command sequencer around the block store and list heads.
// An unused op or a request rejected up front goes straight to the finish state; a size query
// or a free rejected after the store read finishes after that read; an allocate unlinks a block
// and splits it level by level, and a free merges with its buddy level by level before the push.
// One item at a time; the next is taken the cycle after the result register loads. Reset and
// each pool_order write first run a clearing pass over all 1024 store entries. Depends on bba_pkg, bba_mem, bba_heads.
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic [CNT_W-1:0] in_size_blocks,
  input  logic [IDX_W-1:0] in_block_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [IDX_W-1:0] out_result_index,
  output logic [CNT_W-1:0] out_block_size,
  output logic [CNT_W-1:0] out_used_blocks,
  output logic [CNT_W-1:0] out_largest_free,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_pool_order
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_ROOT   = 12'b000000000010,
    S_IDLE   = 12'b000000000100,
    S_EVAL   = 12'b000000001000,
    S_MERGE  = 12'b000000010000,
    S_UNL_P  = 12'b000000100000,
    S_UNL_N  = 12'b000001000000,
    S_UNL_S  = 12'b000010000000,
    S_SPLIT  = 12'b000100000000,
    S_PUSH_S = 12'b001000000000,
    S_PUSH_H = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [LVL_W-1:0]  eff_r, eff_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              merge_r, merge_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  bud_r, bud_nxt;
  logic [LVL_W-1:0]  cur_r, cur_nxt;
  logic [LVL_W-1:0]  tgt_r, tgt_nxt;
  logic [LINK_W-1:0] p_r, p_nxt;
  logic [LINK_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [IDX_W-1:0]  ri_r, ri_nxt;
  logic [CNT_W-1:0]  bs_r, bs_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [IDX_W-1:0]  out_ri_r;
  logic [CNT_W-1:0]  out_bs_r, out_used_r, out_lf_r;
  logic              out_load;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  wr_t               mem_wr;
  logic              mem_we;

  logic              hd_clr, hd_wr_en;
  logic [LVL_W-1:0]  hd_wr_lvl, req_lvl;
  logic [LINK_W-1:0] hd_wr_val, head_sel;
  fit_t              fit;
  logic [CNT_W-1:0]  largest;

  logic [CNT_W-1:0]  pool;
  logic [IDX_W-1:0]  push_tgt;

  bba_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (mem_wr)
  );

  bba_heads u_heads (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (hd_clr),
    .wr_en    (hd_wr_en),
    .wr_lvl   (hd_wr_lvl),
    .wr_val   (hd_wr_val),
    .eff      (eff_r),
    .req_lvl  (req_lvl),
    .sel_lvl  (cur_r),
    .head_sel (head_sel),
    .fit      (fit),
    .largest  (largest)
  );

  assign pool     = CNT_W'(1) << eff_r;
  assign req_lvl  = ceil_lvl(in_size_blocks);
  assign push_tgt = (op_r == OP_ALLOC) ? bud_r : idx_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;

  // Command sequencer.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    eff_nxt     = eff_r;
    op_nxt      = op_r;
    merge_nxt   = merge_r;
    idx_nxt     = idx_r;
    bud_nxt     = bud_r;
    cur_nxt     = cur_r;
    tgt_nxt     = tgt_r;
    p_nxt       = p_r;
    n_nxt       = n_r;
    used_nxt    = used_r;
    st_nxt      = st_r;
    ri_nxt      = ri_r;
    bs_nxt      = bs_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    mem_wr      = '0;
    hd_clr      = 1'b0;
    hd_wr_en    = 1'b0;
    hd_wr_lvl   = cur_r;
    hd_wr_val   = LINK_NULL;
    out_load    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        hd_clr       = 1'b1;
        mem_wr       = '{we_prev: 1'b1, we_next: 1'b1, we_lvl: 1'b1, we_mark: 1'b1,
                         addr: clr_cnt_r,
                         data: '{mark: 1'b0, lvl: LEVEL_NONE, prev: LINK_OUT, next: LINK_OUT}};
        clr_cnt_nxt  = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == '1) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        mem_wr    = '{we_prev: 1'b1, we_next: 1'b1, we_lvl: 1'b1, we_mark: 1'b1,
                      addr: '0,
                      data: '{mark: 1'b0, lvl: eff_r, prev: LINK_NULL, next: LINK_NULL}};
        hd_wr_en  = 1'b1;
        hd_wr_lvl = eff_r;
        hd_wr_val = '0;
        used_nxt  = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          eff_nxt     = (cfg_pool_order > ROOT_MAX) ? ROOT_MAX : cfg_pool_order;
          used_nxt    = '0;
          clr_cnt_nxt = '0;
          state_nxt   = S_CLEAR;
        end else if (in_valid) begin
          op_nxt    = in_op;
          merge_nxt = 1'b0;
          st_nxt    = ST_OK;
          ri_nxt    = '0;
          bs_nxt    = '0;
          if (in_op == OP_ALLOC) begin
            if ((req_lvl > eff_r) || !fit.found) begin
              st_nxt    = ST_OOM;
              state_nxt = S_FIN;
            end else begin
              idx_nxt   = fit.head;
              cur_nxt   = fit.lvl;
              tgt_nxt   = req_lvl;
              rd_en     = 1'b1;
              rd_addr   = fit.head;
              state_nxt = S_EVAL;
            end
          end else if ((in_op == OP_FREE) || (in_op == OP_QUERY)) begin
            idx_nxt = in_block_index;
            if ({1'b0, in_block_index} >= pool) begin
              st_nxt    = ST_BAD;
              state_nxt = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = in_block_index;
              state_nxt = S_EVAL;
            end
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_EVAL: begin
        if (op_r == OP_ALLOC) begin
          p_nxt     = rd_data.prev;
          n_nxt     = rd_data.next;
          state_nxt = S_UNL_P;
        end else if (merge_r) begin
          // Buddy joins only if it is a free list entry of the same level.
          if (!rd_data.mark && (rd_data.lvl == cur_r) && (rd_data.prev != LINK_OUT)) begin
            p_nxt     = rd_data.prev;
            n_nxt     = rd_data.next;
            state_nxt = S_UNL_P;
          end else begin
            state_nxt = S_PUSH_S;
          end
        end else if (!rd_data.mark || (rd_data.lvl > eff_r)) begin
          st_nxt    = ST_BAD;
          state_nxt = S_FIN;
        end else if (op_r == OP_QUERY) begin
          bs_nxt    = CNT_W'(1) << rd_data.lvl;
          state_nxt = S_FIN;
        end else begin
          cur_nxt   = rd_data.lvl;
          used_nxt  = used_r - (CNT_W'(1) << rd_data.lvl);
          merge_nxt = 1'b1;
          mem_wr    = '{we_prev: 1'b0, we_next: 1'b0, we_lvl: 1'b1, we_mark: 1'b1,
                        addr: idx_r,
                        data: '{mark: 1'b0, lvl: LEVEL_NONE, prev: LINK_OUT, next: LINK_OUT}};
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (cur_r < eff_r) begin
          bud_nxt   = idx_r ^ (IDX_W'(1) << cur_r);
          rd_en     = 1'b1;
          rd_addr   = idx_r ^ (IDX_W'(1) << cur_r);
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_PUSH_S;
        end
      end
      S_UNL_P: begin
        if (p_r[LINK_W-1]) begin
          hd_wr_en  = 1'b1;
          hd_wr_val = n_r;
        end else begin
          mem_wr.we_next   = 1'b1;
          mem_wr.addr      = p_r[IDX_W-1:0];
          mem_wr.data.next = n_r;
        end
        state_nxt = S_UNL_N;
      end
      S_UNL_N: begin
        if (!n_r[LINK_W-1]) begin
          mem_wr.we_prev   = 1'b1;
          mem_wr.addr      = n_r[IDX_W-1:0];
          mem_wr.data.prev = p_r;
        end
        state_nxt = S_UNL_S;
      end
      S_UNL_S: begin
        if (op_r == OP_ALLOC) begin
          mem_wr    = '{we_prev: 1'b1, we_next: 1'b1, we_lvl: 1'b1, we_mark: 1'b1,
                        addr: idx_r,
                        data: '{mark: 1'b1, lvl: tgt_r, prev: LINK_OUT, next: LINK_OUT}};
          state_nxt = S_SPLIT;
        end else begin
          mem_wr    = '{we_prev: 1'b1, we_next: 1'b1, we_lvl: 1'b1, we_mark: 1'b1,
                        addr: bud_r,
                        data: '{mark: 1'b0, lvl: LEVEL_NONE, prev: LINK_OUT, next: LINK_OUT}};
          if (bud_r < idx_r) idx_nxt = bud_r;
          cur_nxt   = cur_r + LVL_W'(1);
          state_nxt = S_MERGE;
        end
      end
      S_SPLIT: begin
        if (cur_r > tgt_r) begin
          bud_nxt   = idx_r ^ (IDX_W'(1) << (cur_r - LVL_W'(1)));
          cur_nxt   = cur_r - LVL_W'(1);
          state_nxt = S_PUSH_S;
        end else begin
          bs_nxt    = CNT_W'(1) << tgt_r;
          used_nxt  = used_r + (CNT_W'(1) << tgt_r);
          ri_nxt    = idx_r;
          state_nxt = S_FIN;
        end
      end
      S_PUSH_S: begin
        mem_wr    = '{we_prev: 1'b1, we_next: 1'b1, we_lvl: 1'b1, we_mark: 1'b1,
                      addr: push_tgt,
                      data: '{mark: 1'b0, lvl: cur_r, prev: LINK_NULL, next: head_sel}};
        state_nxt = S_PUSH_H;
      end
      S_PUSH_H: begin
        if (!head_sel[LINK_W-1]) begin
          mem_wr.we_prev   = 1'b1;
          mem_wr.addr      = head_sel[IDX_W-1:0];
          mem_wr.data.prev = {1'b0, push_tgt};
        end
        hd_wr_en  = 1'b1;
        hd_wr_val = {1'b0, push_tgt};
        state_nxt = (op_r == OP_ALLOC) ? S_SPLIT : S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);

  // Any field of the block store is being written this cycle.
  assign mem_we = mem_wr.we_prev | mem_wr.we_next | mem_wr.we_lvl | mem_wr.we_mark;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      eff_r       <= ROOT_MAX;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      op_r        <= OP_ALLOC;
      merge_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      eff_r       <= eff_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      merge_r     <= merge_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    bud_r <= bud_nxt;
    cur_r <= cur_nxt;
    tgt_r <= tgt_nxt;
    p_r   <= p_nxt;
    n_r   <= n_nxt;
    st_r  <= st_nxt;
    ri_r  <= ri_nxt;
    bs_r  <= bs_nxt;
    if (out_load) begin
      out_status_r <= st_r;
      out_ri_r     <= ri_r;
      out_bs_r     <= bs_r;
      out_used_r   <= used_r;
      out_lf_r     <= largest;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_ri_r;
  assign out_block_size   = out_bs_r;
  assign out_used_blocks  = out_used_r;
  assign out_largest_free = out_lf_r;

  // The store is never written while waiting for a command.
  `BBA_ASSERT_IMP(a_idle_no_write, state_r == S_IDLE, !mem_we, "block store written while idle")
  // Allocated blocks never exceed the pool.
  `BBA_ASSERT(a_used_in_pool, used_r <= pool, "used block count exceeds pool size")
  // The clearing pass leaves every free list empty before the root is placed.
  `BBA_ASSERT_IMP(a_root_after_clear, state_r == S_ROOT, largest == '0, "lists not empty after clear")
  // A transfer is only offered for a finished command.
  `BBA_ASSERT_IMP(a_load_from_fin, out_load, state_r == S_FIN, "result loaded outside finish")

endmodule

@@ sim/tb_buddy_block_allocator.sv @@
// Self-checking testbench for the buddy block allocator: random and directed commands,
// predicted results compared field by field. Depends on bba_pkg and buddy_block_allocator.
module tb_buddy_block_allocator;
  import bba_pkg::*;

  typedef struct packed {
    logic [1:0]       op;
    logic [CNT_W-1:0] size;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] res_idx;
    logic [CNT_W-1:0] bsize;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] largest;
  } rsp_t;

  localparam int LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic [CNT_W-1:0] in_size_blocks = '0;
  logic [IDX_W-1:0] in_block_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [IDX_W-1:0] out_result_index;
  logic [CNT_W-1:0] out_block_size, out_used_blocks, out_largest_free;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_pool_order = 4'd10;

  buddy_block_allocator dut (.*);

  always #5 clk = ~clk;

  // Allocator shadow state.
  logic [LINK_W-1:0] m_prev [NUM_BLOCKS];
  logic [LINK_W-1:0] m_next [NUM_BLOCKS];
  logic [LVL_W-1:0]  m_lvl  [NUM_BLOCKS];
  logic              m_mark [NUM_BLOCKS];
  logic [LINK_W-1:0] m_head [MAX_LEVELS];
  int                m_order;

  cmd_t pending_cmds[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   cycles = 0;
  bit   quiet_tail = 0;
  bit   gate_sender = 0;
  bit   stall_rx = 0;
  int   hold_off = 0;
  int   gap = 0;

  function automatic void push_free(int idx, int lvl);
    logic [LINK_W-1:0] h;
    h = m_head[lvl];
    m_prev[idx] = LINK_NULL;
    m_next[idx] = h;
    m_lvl[idx] = LVL_W'(lvl);
    if (h < NUM_BLOCKS) m_prev[h] = LINK_W'(idx);
    m_head[lvl] = LINK_W'(idx);
  endfunction

  function automatic void unlink_free(int idx, int lvl);
    logic [LINK_W-1:0] p, n;
    p = m_prev[idx];
    n = m_next[idx];
    if (p >= NUM_BLOCKS) m_head[lvl] = n;
    else m_next[p] = n;
    if (n < NUM_BLOCKS) m_prev[n] = p;
    m_prev[idx] = LINK_OUT;
    m_next[idx] = LINK_OUT;
  endfunction

  function automatic void init_pool(int order);
    m_order = (order > MAX_LEVELS - 1) ? MAX_LEVELS - 1 : order;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      m_prev[i] = LINK_OUT;
      m_next[i] = LINK_OUT;
      m_lvl[i] = LEVEL_NONE;
      m_mark[i] = 1'b0;
    end
    for (int i = 0; i < MAX_LEVELS; i++) m_head[i] = LINK_NULL;
    push_free(0, m_order);
  endfunction

  int used_total;

  // Applies one command to the shadow allocator and returns the result it should give.
  function automatic rsp_t apply_cmd(cmd_t c);
    rsp_t r;
    int lvl, l, blk, bud, idx, sz, t, pool;
    r = '0;
    pool = 1 << m_order;
    idx = c.idx;
    if (c.op == OP_ALLOC) begin
      sz = (c.size == 0) ? 1 : c.size;
      lvl = 0;
      while ((1 << lvl) < sz) lvl++;
      if (lvl > m_order) r.status = ST_OOM;
      else begin
        l = lvl;
        while (l <= m_order && m_head[l] >= NUM_BLOCKS) l++;
        if (l > m_order) r.status = ST_OOM;
        else begin
          blk = m_head[l];
          unlink_free(blk, l);
          while (l > lvl) begin
            l--;
            push_free(blk ^ (1 << l), l);
          end
          r.bsize = CNT_W'(1 << lvl);
          used_total += 1 << lvl;
          for (int i = blk; i < blk + (1 << lvl); i++) m_lvl[i] = LVL_W'(lvl);
          m_mark[blk] = 1'b1;
          r.res_idx = IDX_W'(blk);
        end
      end
    end else if (c.op == OP_FREE || c.op == OP_QUERY) begin
      if (idx >= pool || !m_mark[idx] || m_lvl[idx] > m_order) r.status = ST_BAD;
      else if (c.op == OP_QUERY) r.bsize = CNT_W'(1 << m_lvl[idx]);
      else begin
        lvl = m_lvl[idx];
        sz = 1 << lvl;
        used_total -= sz;
        m_mark[idx] = 1'b0;
        for (int i = idx; i < idx + sz; i++) m_lvl[i] = LEVEL_NONE;
        while (lvl < m_order) begin
          bud = idx ^ (1 << lvl);
          if (bud >= pool) break;
          if (m_mark[bud] || m_lvl[bud] != lvl || m_prev[bud] == LINK_OUT) break;
          unlink_free(bud, lvl);
          if (bud < idx) begin
            t = idx;
            idx = bud;
            bud = t;
          end
          m_lvl[bud] = LEVEL_NONE;
          m_prev[bud] = LINK_OUT;
          m_next[bud] = LINK_OUT;
          lvl++;
        end
        push_free(idx, lvl);
      end
    end
    r.used = CNT_W'(used_total);
    for (int k = m_order; k >= 0; k--) begin
      if (m_head[k] < NUM_BLOCKS) begin
        r.largest = CNT_W'(1 << k);
        break;
      end
    end
    return r;
  endfunction

  // Driver: offers queued commands, with random gaps between transfers.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && in_ready) pending_cmds.pop_front();
    if (in_valid && !in_ready) begin
      // keep offering the same command
    end else if (gap > 0) begin
      gap <= gap - 1;
      in_valid <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      gap <= $urandom_range(1, 12);
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (pending_cmds.size() > 0 && !gate_sender) begin
          in_op <= pending_cmds[0].op;
          in_size_blocks <= pending_cmds[0].size;
          in_block_index <= pending_cmds[0].idx;
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0 && !gate_sender && rst_n && !cfg_valid) begin
        in_op <= pending_cmds[0].op;
        in_size_blocks <= pending_cmds[0].size;
        in_block_index <= pending_cmds[0].idx;
        in_valid <= 1'b1;
      end
    end
  end

  // Prediction on each accepted command.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_rsps.push_back(apply_cmd('{in_op, in_size_blocks, in_block_index}));
  end

  // Monitor: random stalls on the result side, checks each transfer.
  always @(posedge clk) begin
    rsp_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_result_index, out_block_size, out_used_blocks,
              out_largest_free};
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors <= errors + 1;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
          errors <= errors + 1;
        end
      end
    end
    if (stall_rx) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      hold_off <= $urandom_range(1, 12);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drain();
    while (pending_cmds.size() > 0 || in_valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_order(int order);
    @(posedge clk);
    cfg_pool_order <= 4'(order);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    init_pool(order);
    used_total = 0;
  endtask

  function automatic void add_cmd(logic [1:0] op, int size, int idx);
    pending_cmds.push_back('{op, CNT_W'(size), IDX_W'(idx)});
  endfunction

  // Mostly small allocations and frees of random indices in the pool; some noise.
  function automatic void add_random(int n, int order);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) add_cmd(OP_ALLOC, ($urandom_range(0, 9) == 0) ?
                              $urandom_range(0, 2047) : $urandom_range(0, 1 << (order / 2 + 1)), 0);
      else if (pick < 80) add_cmd(OP_FREE, 0, $urandom_range(0, (1 << order) - 1));
      else if (pick < 90) add_cmd(OP_QUERY, 0, $urandom_range(0, 1023));
      else add_cmd(2'(pick % 4), $urandom_range(0, 2047), $urandom_range(0, 1023));
    end
  endfunction

  int orders[5] = '{10, 0, 3, 15, 6};

  initial begin
    init_pool(10);
    used_total = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, zero size, too large, exhaustion, bad frees, unused op.
    add_cmd(OP_ALLOC, 0, 0);
    add_cmd(OP_ALLOC, 2047, 0);
    add_cmd(OP_ALLOC, 1024, 0);
    add_cmd(OP_ALLOC, 1, 0);
    add_cmd(OP_QUERY, 0, 0);
    add_cmd(OP_FREE, 0, 0);
    add_cmd(OP_FREE, 0, 0);
    add_cmd(OP_ALLOC, 1, 0);
    add_cmd(OP_ALLOC, 3, 0);
    add_cmd(OP_ALLOC, 513, 0);
    add_cmd(OP_QUERY, 0, 1023);
    add_cmd(OP_FREE, 0, 5);
    add_cmd(2'd3, 2047, 1023);
    add_cmd(OP_FREE, 0, 4);
    add_cmd(OP_FREE, 0, 0);
    add_cmd(OP_ALLOC, 512, 0);
    add_cmd(OP_ALLOC, 512, 0);
    add_cmd(OP_ALLOC, 1, 0);
    add_cmd(OP_FREE, 0, 512);
    add_cmd(OP_FREE, 0, 0);
    wait_drain();
    // Long receiver hold-off while the sender keeps offering.
    add_random(60, 10);
    stall_rx <= 1'b1;
    repeat (400) @(posedge clk);
    stall_rx <= 1'b0;
    wait_drain();
    for (int p = 0; p < 5; p++) begin
      write_order(orders[p]);
      gate_sender = 1;
      add_random(p == 0 ? 300 : 150, orders[p] > 10 ? 10 : orders[p]);
      if (p == 4) quiet_tail = 1;
      gate_sender = 0;
      wait_drain();
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  final_check: assert property (@(posedge clk) 1);
endmodule
